@@ rtl/crcse_pkg.sv @@
`timescale 1ns / 1ps

package crcse_pkg;

  // Reflected Castagnoli polynomial and basic widths.
  localparam logic [31:0] CRC_POLY  = 32'h82F63B78;
  localparam logic [7:0]  BYTE_MASK = 8'hFF;
  localparam int unsigned CRC_W     = 32;
  localparam int unsigned BYTE_W    = 8;
  // Wide enough to hold a byte count of up to sixteen.
  localparam int unsigned CNT_W     = 5;

  // Per-word sideband that travels down the pipeline next to the lane data.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             first;
    logic [CRC_W-1:0] seed;
    logic             last;
  } ctrl_t;

  // One reflected polynomial step.
  function automatic logic [CRC_W-1:0] crc_step_bit(logic [CRC_W-1:0] r);
    return r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
  endfunction

  // CRC register after one byte, starting from an all-zero register.
  function automatic logic [CRC_W-1:0] crc_byte_table(logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = {24'h0, b & BYTE_MASK};
    for (int k = 0; k < 8; k++) begin
      r = crc_step_bit(r);
    end
    return r;
  endfunction

  // Advances a register over a number of zero bytes. Only called with
  // constant arguments, so it folds into a fixed XOR matrix.
  function automatic logic [CRC_W-1:0] crc_zero_adv(logic [CRC_W-1:0] r_in, int nbytes);
    logic [CRC_W-1:0] r;
    r = r_in;
    for (int k = 0; k < 8 * nbytes; k++) begin
      r = crc_step_bit(r);
    end
    return r;
  endfunction

endpackage

@@ rtl/crcse_lane.sv @@
`timescale 1ns / 1ps

module crcse_lane #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [7:0]             byte_i,
  output logic [crcse_pkg::CRC_W-1:0] contrib_o
);
  import crcse_pkg::*;

  logic [CRC_W-1:0] tbl;
  logic [CRC_W-1:0] term [CRC_W];
  logic [CRC_W-1:0] contrib_d;
  logic [CRC_W-1:0] contrib_q;

  // Byte CRC from a zero register.
  assign tbl = crc_byte_table(byte_i);

  // Fixed advance over the zero bytes that follow this lane in the word.
  for (genvar j = 0; j < CRC_W; j++) begin : g_col
    localparam logic [CRC_W-1:0] COL = crc_zero_adv(CRC_W'(1) << j, SHIFT);
    assign term[j] = tbl[j] ? COL : '0;
  end

  always_comb begin
    contrib_d = '0;
    for (int j = 0; j < CRC_W; j++) begin
      contrib_d = contrib_d ^ term[j];
    end
  end

  // Lane result register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      contrib_q <= contrib_d;
    end
  end

  assign contrib_o = contrib_q;

endmodule

@@ rtl/crcse_merge.sv @@
`timescale 1ns / 1ps

module crcse_merge #(
  parameter int unsigned LANES = 8
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [LANES*crcse_pkg::CRC_W-1:0]  lanes_i,
  output logic [crcse_pkg::CRC_W-1:0]        sum_o
);
  import crcse_pkg::*;

  logic [CRC_W-1:0] sum_d;
  logic [CRC_W-1:0] sum_q;

  // The CRC is linear, so the lane contributions combine by XOR.
  always_comb begin
    sum_d = '0;
    for (int p = 0; p < LANES; p++) begin
      sum_d = sum_d ^ lanes_i[p*CRC_W +: CRC_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

@@ rtl/crcse_accum.sv @@
`timescale 1ns / 1ps

module crcse_accum #(
  parameter int unsigned BYTES = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [crcse_pkg::CRC_W-1:0]  sum_i,
  input  crcse_pkg::ctrl_t             ctrl_i,
  output logic [crcse_pkg::CRC_W-1:0]  crc_value_o,
  output logic                         is_last_o
);
  import crcse_pkg::*;

  logic [CRC_W-1:0] zcol [BYTES+1][CRC_W];
  logic [CRC_W-1:0] start;
  logic [CRC_W-1:0] adv;
  logic [CRC_W-1:0] col;
  logic [CRC_W-1:0] crc_d;
  logic [CRC_W-1:0] crc_q;
  logic             is_last_q;

  // Columns of the zero-byte advance matrix for every possible count.
  for (genvar n = 0; n <= BYTES; n++) begin : g_cnt
    for (genvar j = 0; j < CRC_W; j++) begin : g_col
      localparam logic [CRC_W-1:0] COL = crc_zero_adv(CRC_W'(1) << j, n);
      assign zcol[n][j] = COL;
    end
  end

  // A first word restarts from the inverted seed.
  assign start = ctrl_i.first ? ~ctrl_i.seed : crc_q;

  // Advance the running register over count bytes, then add the data term.
  always_comb begin
    adv = '0;
    col = '0;
    for (int j = 0; j < CRC_W; j++) begin
      col = '0;
      for (int k = 0; k <= BYTES; k++) begin
        if (ctrl_i.count == CNT_W'(k)) begin
          col = zcol[k][j];
        end
      end
      adv = adv ^ (start[j] ? col : '0);
    end
    crc_d = adv ^ sum_i;
  end

  // Running CRC register; reset matches a message started from seed zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '1;
    end else if (en_i) begin
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      is_last_q <= ctrl_i.last;
    end
  end

  assign crc_value_o = ~crc_q;
  assign is_last_o   = is_last_q;

endmodule

@@ rtl/crc32c_stream_engine_unit.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o  data_bytes_i, byte_count_i, first_i, seed_i, last_i
// out      output     out_valid_o / out_ready_i crc_value_o, is_last_o
//
// One word is taken every cycle while in_ready_o is high; its result passes the lane, merge and accumulator registers.
// The only feedback loop is the running register update: a count-selected
// zero-byte advance matrix followed by the XOR with the merged lane term.
// Reset clears all valid bits and sets the running register to all ones.
// Each stage holds its word while the next stage is full and stalled.

module crc32c_stream_engine_unit #(
  parameter int unsigned BYTES_PER_ITEM = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_bytes_i,
  input  logic [3:0]  byte_count_i,
  input  logic        first_i,
  input  logic [31:0] seed_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] crc_value_o,
  output logic        is_last_o
);
  import crcse_pkg::*;

  localparam int unsigned AW = 8 * BYTES_PER_ITEM + 64;

  logic                              rdy1, rdy2, rdy3;
  logic                              en1, en2, en3;
  logic                              v1_q, v2_q, v3_q;
  logic [CNT_W-1:0]                  count_sat;
  logic [AW-1:0]                     ext;
  logic [AW-1:0]                     shifted;
  logic [8*BYTES_PER_ITEM-1:0]       aligned;
  logic [BYTES_PER_ITEM*CRC_W-1:0]   lanes;
  logic [CRC_W-1:0]                  sum;
  ctrl_t                             ctrl1_d, ctrl1_q, ctrl2_q;

  // Per-stage ready: a stage takes a word when empty or when it drains.
  assign rdy3 = ~v3_q | out_ready_i;
  assign rdy2 = ~v2_q | rdy3;
  assign rdy1 = ~v1_q | rdy2;
  assign en1  = in_valid_i & rdy1;
  assign en2  = v1_q & rdy2;
  assign en3  = v2_q & rdy3;

  assign in_ready_o  = rdy1;
  assign out_valid_o = v3_q;

  // Saturate the byte count at the word size.
  assign count_sat = (CNT_W'(byte_count_i) > CNT_W'(BYTES_PER_ITEM)) ?
                     CNT_W'(BYTES_PER_ITEM) : CNT_W'(byte_count_i);

  // Right-align the valid bytes so that each lane has a fixed tail length.
  // Leading zero bytes leave a zero register unchanged, and bytes above the
  // count fall off the top.
  assign ext     = AW'(data_bytes_i);
  assign shifted = ext << (8 * (BYTES_PER_ITEM - int'(count_sat)));
  assign aligned = shifted[8*BYTES_PER_ITEM-1:0];

  assign ctrl1_d = '{count: count_sat, first: first_i, seed: seed_i, last: last_i};

  // Byte lanes.
  for (genvar p = 0; p < BYTES_PER_ITEM; p++) begin : g_lane
    crcse_lane #(
      .SHIFT(BYTES_PER_ITEM - 1 - p)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (en1),
      .byte_i   (aligned[8*p +: 8]),
      .contrib_o(lanes[CRC_W*p +: CRC_W])
    );
  end

  // Merge of the lane contributions.
  crcse_merge #(
    .LANES(BYTES_PER_ITEM)
  ) u_merge (
    .clk_i  (clk_i),
    .en_i   (en2),
    .lanes_i(lanes),
    .sum_o  (sum)
  );

  // Running register and output word.
  crcse_accum #(
    .BYTES(BYTES_PER_ITEM)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en3),
    .sum_i      (sum),
    .ctrl_i     (ctrl2_q),
    .crc_value_o(crc_value_o),
    .is_last_o  (is_last_o)
  );

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Sideband that follows the lane data.
  always_ff @(posedge clk_i) begin
    if (en1) begin
      ctrl1_q <= ctrl1_d;
    end
    if (en2) begin
      ctrl2_q <= ctrl1_q;
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int unsigned BYTES_PER_ITEM  = 8;
  localparam logic [31:0] CASTAGNOLI_POLY = 32'h82F6_3B78;
  localparam int unsigned RANDOM_WORDS    = 1400;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned DRAIN_CYCLES    = 12;
  localparam int unsigned CALM_START      = 700;
  localparam int unsigned CALM_STOP       = 1100;
  localparam int unsigned N_DIRECTED      = 22;

  localparam logic [63:0] ASCII_1TO8 = 64'h3837_3635_3433_3231;
  localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;

  // One directed word, with an optional hand-computed CRC.
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        first;
    logic [31:0] seed;
    logic        last;
    logic        typed;
    logic [31:0] crc;
  } vector_t;

  typedef struct packed {
    logic [31:0] crc;
    logic        last;
  } crc_result_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [63:0] data_bytes_i = '0;
  logic [3:0]  byte_count_i = '0;
  logic        first_i      = 1'b0;
  logic [31:0] seed_i       = '0;
  logic        last_i       = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [31:0] crc_value_o;
  logic        is_last_o;

  // Hand-computed CRC that travels with the word on the input side.
  logic        word_typed   = 1'b0;
  logic [31:0] word_crc     = '0;

  logic [31:0]    crc_state = 32'hFFFF_FFFF;
  crc_result_t    crc_expect_q[$];
  int unsigned    mismatches = 0;
  int unsigned    cyc_cnt = 0;
  int unsigned    quiet_cycles = 0;
  logic           calm;

  // Directed words, among them well-known check values: "123456789", and 32 bytes of zeros or of ones.
  vector_t dir_tab [N_DIRECTED] = '{
    '{64'h0,                  4'd0,  1'b0, 32'h0,         1'b0, 1'b1, 32'h0000_0000},
    '{ALL_ONES,               4'd0,  1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
    '{64'h0,                  4'd0,  1'b1, 32'h1234_5678, 1'b0, 1'b1, 32'h1234_5678},
    '{64'h0,                  4'd0,  1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
    '{ASCII_1TO8,             4'd8,  1'b1, 32'h0,         1'b0, 1'b0, 32'h0},
    '{64'h39,                 4'd1,  1'b0, 32'h0,         1'b1, 1'b1, 32'hE306_9283},
    '{64'h0,                  4'd8,  1'b1, 32'h0,         1'b0, 1'b0, 32'h0},
    '{64'h0,                  4'd8,  1'b0, 32'h0,         1'b0, 1'b0, 32'h0},
    '{64'h0,                  4'd8,  1'b0, 32'h0,         1'b0, 1'b0, 32'h0},
    '{64'h0,                  4'd8,  1'b0, 32'h0,         1'b1, 1'b1, 32'h8A91_36AA},
    '{ALL_ONES,               4'd8,  1'b1, 32'h0,         1'b0, 1'b0, 32'h0},
    '{ALL_ONES,               4'd8,  1'b0, 32'h0,         1'b0, 1'b0, 32'h0},
    '{ALL_ONES,               4'd8,  1'b0, 32'h0,         1'b0, 1'b0, 32'h0},
    '{ALL_ONES,               4'd8,  1'b0, 32'h0,         1'b1, 1'b1, 32'h62A8_AB43},
    '{ALL_ONES,               4'd15, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{64'hA5A5_A5A5_A5A5_A5A5, 4'd9, 1'b0, 32'h0,         1'b0, 1'b0, 32'h0},
    '{64'hFFFF_FFFF_FFFF_FF00, 4'd1, 1'b1, 32'h5A5A_0F0F, 1'b0, 1'b0, 32'h0},
    '{64'h0000_0000_0000_00FF, 4'd7, 1'b0, 32'h0,         1'b0, 1'b0, 32'h0},
    '{64'h0123_4567_89AB_CDEF, 4'd4, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
    '{64'hFEDC_BA98_7654_3210, 4'd2, 1'b0, 32'h0,         1'b1, 1'b0, 32'h0},
    '{64'h5555_5555_5555_5555, 4'd8, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ALL_ONES,               4'd0,  1'b0, 32'h0,         1'b1, 1'b0, 32'h0}
  };

  crc32c_stream_engine_unit #(
    .BYTES_PER_ITEM(BYTES_PER_ITEM)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_bytes_i(data_bytes_i),
    .byte_count_i(byte_count_i),
    .first_i     (first_i),
    .seed_i      (seed_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .crc_value_o (crc_value_o),
    .is_last_o   (is_last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Neither side idles inside this window of cycles.
  assign calm = (cyc_cnt >= CALM_START) && (cyc_cnt < CALM_STOP);

  // Running CRC register after one word: reload on first, then fold in each
  // valid byte, least significant bit first. Counts above the word size
  // saturate.
  function automatic logic [31:0] crc_advance(logic [31:0] reg_in, logic [63:0] data,
                                               logic [3:0] count, logic first,
                                               logic [31:0] seed);
    logic [31:0] r;
    int unsigned n;
    r = first ? ~seed : reg_in;
    n = (count > BYTES_PER_ITEM) ? BYTES_PER_ITEM : count;
    for (int i = 0; i < n; i++) begin
      r = r ^ {24'h0, data[8*i +: 8]};
      for (int b = 0; b < 8; b++) begin
        r = r[0] ? ((r >> 1) ^ CASTAGNOLI_POLY) : (r >> 1);
      end
    end
    return r;
  endfunction

  // Mostly full words, with short ones, empty ones and oversized counts mixed in.
  function automatic logic [3:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) begin
      return 4'd8;
    end else if (r < 90) begin
      return 4'($urandom_range(1, 7));
    end else if (r < 95) begin
      return 4'd0;
    end
    return 4'($urandom_range(9, 15));
  endfunction

  // Presents one word and holds it until the block takes it.
  task automatic send_word(input logic [63:0] data, input logic [3:0] count,
                           input logic first, input logic [31:0] seed,
                           input logic last, input logic typed, input logic [31:0] crc);
    if (!calm && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_bytes_i <= data;
    byte_count_i <= count;
    first_i      <= first;
    seed_i       <= seed;
    last_i       <= last;
    word_typed   <= typed;
    word_crc     <= crc;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
  endtask

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 16);
  end

  // Prediction on accepted input words, checking on accepted results, and a
  // watchdog on cycles in which no word moves on either side.
  always @(posedge clk_i) begin : monitor
    crc_result_t want;
    crc_result_t got;
    if (rst_ni) begin
      cyc_cnt <= cyc_cnt + 1;
      if (in_valid_i && in_ready_o) begin
        crc_state = crc_advance(crc_state, data_bytes_i, byte_count_i, first_i, seed_i);
        want.crc  = word_typed ? word_crc : ~crc_state;
        want.last = last_i;
        crc_expect_q.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        if (crc_expect_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result crc_value %08h is_last %0b", $time,
                   crc_value_o, is_last_o);
        end else begin
          want = crc_expect_q.pop_front();
          got.crc  = crc_value_o;
          got.last = is_last_o;
          if (got.crc !== want.crc) begin
            mismatches++;
            $display("%0t: crc_value expected %08h, got %08h", $time, want.crc, got.crc);
          end
          if (got.last !== want.last) begin
            mismatches++;
            $display("%0t: is_last expected %0b, got %0b", $time, want.last, got.last);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned msg_len;
    logic [31:0] seed;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words.
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_word(dir_tab[i].data, dir_tab[i].count, dir_tab[i].first, dir_tab[i].seed,
                dir_tab[i].last, dir_tab[i].typed, dir_tab[i].crc);
    end

    // Random part: mostly whole messages that start from a seed and end with
    // last; the rest are loose words with random flags and any count.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(99) < 85) begin
        msg_len = ($urandom_range(19) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
        seed    = ($urandom_range(3) == 0) ? 32'h0 : $urandom();
        for (int k = 0; k < msg_len; k++) begin
          send_word({$urandom(), $urandom()}, pick_count(), k == 0,
                    (k == 0) ? seed : $urandom(), k == msg_len - 1, 1'b0, 32'h0);
        end
        sent += msg_len;
      end else begin
        send_word({$urandom(), $urandom()}, 4'($urandom_range(15)), 1'($urandom()),
                  $urandom(), 1'($urandom()), 1'b0, 32'h0);
        sent++;
      end
    end
    in_valid_i <= 1'b0;

    // Let every outstanding result come back, then watch for strays.
    while (crc_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
